[design/pbca_pkg.sv]
// Package for the peer bandwidth cap allocator: payload types, control struct, constants.
package pbca_pkg;

   localparam int MAX_PEERS_DEF = 32;
   localparam int MAX_PEERS_TOP = 64;
   localparam int DIV_BITS = 54;
   localparam int DVS_BITS = 38;
   localparam int SUM_BITS = 38;
   localparam logic [17:0] Q16_ONE = 18'd65536;

   localparam logic [1:0] CSR_TOTAL_IN = 2'd0;
   localparam logic [1:0] CSR_TOTAL_OUT = 2'd1;
   localparam logic [1:0] CSR_PEER_IN = 2'd2;
   localparam logic [1:0] CSR_PEER_OUT = 2'd3;

   typedef struct packed {
      logic [31:0] rate_in;
      logic [31:0] cap_in;
      logic [31:0] rate_out;
      logic [31:0] cap_out;
      logic last_peer;
   } req_type;

   typedef struct packed {
      logic [4:0] peer_index;
      logic [31:0] new_cap_in;
      logic [31:0] new_cap_out;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic [5:0] wr_addr;
      logic rd_en;
      logic [5:0] rd_addr;
      logic [6:0] n;
      logic div_start;
      logic div_step;
      logic div_share;
      logic share_ld;
      logic sum_en;
      logic mode_en;
      logic ratio_ld;
      logic mul_en;
   } ctl_type;

endpackage

[design/peer_bandwidth_cap_allocator_unit.sv]
// Top level of the peer bandwidth cap allocator: registers, sequencer, result port.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  req      | start / busy          | req_data (req_type)
//  rsp      | rsp_valid, one cycle  | rsp_data (rsp_type)
//  csr      | csr_valid / csr_ready | csr_index, csr_data
//
// Items load at one per cycle while idle. On the last item the shared divider runs
// for the fair share, the sum pass reads and accumulates each peer, the mode is
// selected, the ratio divide runs, and the output pass reads, multiplies and emits
// each peer while busy is high. Each result passes the multiplier and result registers.
// Synchronous reset clears the peer count, total limits and sequencer; peer limits reset to 3.
// The receiver cannot stall; results strobe out one peer at a time; csr_ready drops while busy.
module peer_bandwidth_cap_allocator_unit import pbca_pkg::*; #(
   parameter int MAX_PEERS = MAX_PEERS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [31:0] csr_data
);
   localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CW = $clog2(MAX_PEERS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_SHARE, S_SUM_RD, S_SUM_ACC, S_MODE, S_DIV_RATIO,
      S_OUT_RD, S_OUT_MUL, S_OUT_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] total_in_ff, total_out_ff, plim_in_ff, plim_out_ff;
   logic [CW-1:0] count_ff, count_in, n_ff, n_in, count_next;
   logic [AW-1:0] idx_ff, idx_in, last_idx;
   logic [5:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   ctl_type ctl;
   logic accept, store;
   logic [31:0] cap_in_new, cap_out_new;

   assign accept = start && state_ff == S_IDLE;
   assign store = accept && count_ff < CW'(MAX_PEERS);
   assign count_next = store ? count_ff + CW'(1) : count_ff;
   assign last_idx = AW'(n_ff - CW'(1));
   assign busy = state_ff != S_IDLE;
   assign csr_ready = state_ff == S_IDLE;

   always_comb begin
      ctl = '0;
      ctl.wr_en = store;
      ctl.wr_addr = 6'(count_ff);
      ctl.rd_addr = 6'(idx_ff);
      ctl.n = 7'(n_ff);
      state_in = state_ff;
      count_in = count_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            count_in = count_next;
            if (accept && req_data.last_peer) begin
               count_in = '0;
               if (count_next != '0) begin
                  n_in = count_next;
                  cnt_in = '0;
                  state_in = S_DIV_SHARE;
               end
            end
         end
         S_DIV_SHARE: begin
            ctl.div_share = 1'b1;
            ctl.div_start = cnt_ff == '0;
            ctl.div_step = cnt_ff != '0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_BITS + 1)) begin
               ctl.div_step = 1'b0;
               ctl.share_ld = 1'b1;
               idx_in = '0;
               state_in = S_SUM_RD;
            end
         end
         S_SUM_RD: begin
            ctl.rd_en = 1'b1;
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            ctl.sum_en = 1'b1;
            idx_in = idx_ff + AW'(1);
            state_in = S_SUM_RD;
            if (idx_ff == last_idx) state_in = S_MODE;
         end
         S_MODE: begin
            ctl.mode_en = 1'b1;
            cnt_in = '0;
            state_in = S_DIV_RATIO;
         end
         S_DIV_RATIO: begin
            ctl.div_start = cnt_ff == '0;
            ctl.div_step = cnt_ff != '0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_BITS + 1)) begin
               ctl.div_step = 1'b0;
               ctl.ratio_ld = 1'b1;
               idx_in = '0;
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            ctl.rd_en = 1'b1;
            state_in = S_OUT_MUL;
         end
         S_OUT_MUL: begin
            ctl.mul_en = 1'b1;
            state_in = S_OUT_EMIT;
         end
         S_OUT_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.peer_index = 5'(idx_ff);
            rsp_in.new_cap_in = cap_in_new;
            rsp_in.new_cap_out = cap_out_new;
            rsp_in.last = idx_ff == last_idx;
            idx_in = idx_ff + AW'(1);
            state_in = S_OUT_RD;
            if (idx_ff == last_idx) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         total_in_ff <= '0;
         total_out_ff <= '0;
         plim_in_ff <= 32'd3;
         plim_out_ff <= 32'd3;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOTAL_IN: total_in_ff <= csr_data;
               CSR_TOTAL_OUT: total_out_ff <= csr_data;
               CSR_PEER_IN: plim_in_ff <= csr_data;
               CSR_PEER_OUT: plim_out_ff <= csr_data;
               default: plim_out_ff <= plim_out_ff;
            endcase
         end
      end
      n_ff <= n_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   pbca_lane #(.MAX_PEERS(MAX_PEERS)) u_lane_in (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .total(total_in_ff),
      .plim(plim_in_ff),
      .wr_rate(req_data.rate_in),
      .wr_cap(req_data.cap_in),
      .new_cap(cap_in_new)
   );

   pbca_lane #(.MAX_PEERS(MAX_PEERS)) u_lane_out (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .total(total_out_ff),
      .plim(plim_out_ff),
      .wr_rate(req_data.rate_out),
      .wr_cap(req_data.cap_out),
      .new_cap(cap_out_new)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

[design/pbca_div.sv]
// Radix-2 restoring divider, one quotient bit per step.
module pbca_div import pbca_pkg::*; (
   input logic clock,
   input logic start,
   input logic step,
   input logic [DIV_BITS-1:0] dividend,
   input logic [DVS_BITS-1:0] divisor,
   output logic [DIV_BITS-1:0] quotient
);
   logic [DVS_BITS:0] rem_ff, rem_in, rem_sh;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;
   logic ge;

   always_comb begin
      rem_sh = {rem_ff[DVS_BITS-1:0], quo_ff[DIV_BITS-1]};
      ge = rem_sh >= {1'b0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (step) begin
         rem_in = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[DIV_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
endmodule

[design/pbca_lane.sv]
// One traffic direction: peer stores, usage sums, divider, multiplier and cap result.
module pbca_lane import pbca_pkg::*; #(
   parameter int MAX_PEERS = MAX_PEERS_DEF
) (
   input logic clock,
   input logic reset,
   input ctl_type ctl,
   input logic [31:0] total,
   input logic [31:0] plim,
   input logic [31:0] wr_rate,
   input logic [31:0] wr_cap,
   output logic [31:0] new_cap
);
   localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

   typedef enum logic [1:0] {M_KEEP, M_FULL, M_SHRINK, M_RAISE} mode_type;

   logic [31:0] rate_mem [MAX_PEERS];
   logic [31:0] cap_mem [MAX_PEERS];
   logic [31:0] rate_ff, cap_ff;
   logic [31:0] share_ff;
   logic [SUM_BITS-1:0] used_ff, used_in, extra_ff, extra_in;
   logic [6:0] hot_cnt_ff, hot_cnt_in;
   mode_type mode_ff, mode_in;
   logic [17:0] ratio_ff, ratio_in;
   logic [49:0] prod_ff;
   logic [31:0] add_ff;
   logic clip_ff;
   logic [17:0] mul_a;
   logic [31:0] mul_b, add_in;
   logic clip_in;
   logic [DIV_BITS-1:0] dividend, quotient;
   logic [DVS_BITS-1:0] divisor;
   logic [42:0] used20;
   logic [42:0] total19;
   logic above;
   logic [16:0] fq;
   logic [34:0] sum;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         rate_mem[ctl.wr_addr[AW-1:0]] <= wr_rate;
         cap_mem[ctl.wr_addr[AW-1:0]] <= wr_cap;
      end
      if (ctl.rd_en) begin
         rate_ff <= rate_mem[ctl.rd_addr[AW-1:0]];
         cap_ff <= cap_mem[ctl.rd_addr[AW-1:0]];
      end
   end

   assign above = rate_ff > share_ff;
   assign used20 = {1'b0, used_ff, 4'b0} + {3'b0, used_ff, 2'b0};
   assign total19 = {7'b0, total, 4'b0} + {10'b0, total, 1'b0} + {11'b0, total};
   assign fq = (quotient > DIV_BITS'(Q16_ONE)) ? Q16_ONE[16:0] : quotient[16:0];

   always_comb begin
      used_in = used_ff;
      extra_in = extra_ff;
      hot_cnt_in = hot_cnt_ff;
      mode_in = mode_ff;
      ratio_in = ratio_ff;
      if (ctl.share_ld) begin
         used_in = '0;
         extra_in = '0;
         hot_cnt_in = '0;
      end else if (ctl.sum_en) begin
         used_in = used_ff + SUM_BITS'(rate_ff);
         if (above) begin
            extra_in = extra_ff + SUM_BITS'(rate_ff - share_ff);
            if (cap_ff == plim) hot_cnt_in = hot_cnt_ff + 7'd1;
         end
      end
      if (ctl.mode_en) begin
         if (total == '0) mode_in = M_FULL;
         else if (used_ff > SUM_BITS'(total)) mode_in = M_SHRINK;
         else if (hot_cnt_ff != ctl.n && used20 < total19) mode_in = M_RAISE;
         else mode_in = M_KEEP;
      end
      if (ctl.ratio_ld) begin
         case (mode_ff)
            M_SHRINK: ratio_in = Q16_ONE - {1'b0, fq};
            M_RAISE: ratio_in = Q16_ONE + {1'b0, quotient[16:0]};
            default: ratio_in = '0;
         endcase
      end
   end

   always_comb begin
      dividend = '0;
      divisor = DVS_BITS'(1);
      if (ctl.div_share) begin
         dividend = DIV_BITS'(total);
         divisor = DVS_BITS'(ctl.n);
      end else if (mode_ff == M_SHRINK) begin
         dividend = {used_ff - SUM_BITS'(total), 16'b0};
         divisor = extra_ff;
      end else if (mode_ff == M_RAISE) begin
         dividend = {SUM_BITS'(total) - used_ff, 16'b0};
         divisor = DVS_BITS'(total);
      end
   end

   pbca_div u_div (
      .clock(clock),
      .start(ctl.div_start),
      .step(ctl.div_step),
      .dividend(dividend),
      .divisor(divisor),
      .quotient(quotient)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      add_in = cap_ff;
      clip_in = 1'b0;
      case (mode_ff)
         M_FULL: add_in = plim;
         M_SHRINK: begin
            add_in = share_ff;
            clip_in = 1'b1;
            if (above) begin
               mul_a = ratio_ff;
               mul_b = rate_ff - share_ff;
            end
         end
         M_RAISE: begin
            if (cap_ff != plim) begin
               clip_in = 1'b1;
               if (cap_ff < share_ff) begin
                  add_in = '0;
                  mul_a = ratio_ff;
                  mul_b = share_ff;
               end else if ({1'b0, rate_ff, 1'b0} > {2'b0, cap_ff}) begin
                  add_in = '0;
                  mul_a = ratio_ff;
                  mul_b = cap_ff;
               end
            end
         end
         default: add_in = cap_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_KEEP;
      end else begin
         mode_ff <= mode_in;
      end
      used_ff <= used_in;
      extra_ff <= extra_in;
      hot_cnt_ff <= hot_cnt_in;
      ratio_ff <= ratio_in;
      if (ctl.share_ld) share_ff <= quotient[31:0];
      if (ctl.mul_en) begin
         prod_ff <= 50'(mul_a) * 50'(mul_b);
         add_ff <= add_in;
         clip_ff <= clip_in;
      end
   end

   assign sum = 35'(add_ff) + 35'(prod_ff[49:16]);
   assign new_cap = (clip_ff && sum > 35'(plim)) ? plim : sum[31:0];
endmodule

[tb/sv/peer_bandwidth_cap_allocator_unit_test.sv]
// Self-checking testbench for the peer bandwidth cap allocator: predicted caps per batch.
`timescale 1ns / 100ps

module peer_bandwidth_cap_allocator_unit_test;
   import pbca_pkg::*;

   localparam int NPEER = 32;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int QDEPTH = 512;

   class cap_scoreboard;
      bit [31:0] total_lim [2];
      bit [31:0] peer_lim [2];
      bit [31:0] rate_mem [2][NPEER];
      bit [31:0] cap_mem [2][NPEER];
      int stored;
      rsp_type exp_q [QDEPTH];
      int head;
      int tail;
      int mismatches;

      function new();
         total_lim[0] = 0;
         total_lim[1] = 0;
         peer_lim[0] = 3;
         peer_lim[1] = 3;
         stored = 0;
         head = 0;
         tail = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return tail - head;
      endfunction

      function void set_reg(logic [1:0] idx, bit [31:0] val);
         case (idx)
            CSR_TOTAL_IN: total_lim[0] = val;
            CSR_TOTAL_OUT: total_lim[1] = val;
            CSR_PEER_IN: peer_lim[0] = val;
            default: peer_lim[1] = val;
         endcase
      endfunction

      function bit [31:0] clip(bit [63:0] v, bit [31:0] lim);
         return (v > {32'd0, lim}) ? lim : v[31:0];
      endfunction

      function bit [31:0] plan_one(int d, int n, int i);
         bit [63:0] share, used, extra, f, p, nv, rate, cap, total, plim;
         int maxed;
         total = total_lim[d];
         plim = peer_lim[d];
         rate = rate_mem[d][i];
         cap = cap_mem[d][i];
         if (total == 0) return plim[31:0];
         share = total / n;
         used = 0;
         extra = 0;
         maxed = 0;
         for (int k = 0; k < n; k++) begin
            used += rate_mem[d][k];
            if (rate_mem[d][k] > share) begin
               if (cap_mem[d][k] == plim[31:0]) maxed++;
               extra += rate_mem[d][k] - share;
            end
         end
         if (used > total) begin
            f = (extra != 0) ? ((used - total) << 16) / extra : 64'd65536;
            if (f > 65536) f = 65536;
            nv = share;
            if (rate > share) nv = share + (((64'd65536 - f) * (rate - share)) >> 16);
            return clip(nv, plim[31:0]);
         end else if (maxed != n && 20 * used < 19 * total) begin
            p = ((total - used) << 16) / total;
            if (cap == plim) return cap[31:0];
            nv = cap;
            if (cap < share) nv = (share * (64'd65536 + p)) >> 16;
            else if (2 * rate > cap) nv = (cap * (64'd65536 + p)) >> 16;
            return clip(nv, plim[31:0]);
         end
         return cap[31:0];
      endfunction

      function void note_item(req_type it);
         rsp_type r;
         if (stored < NPEER) begin
            rate_mem[0][stored] = it.rate_in;
            cap_mem[0][stored] = it.cap_in;
            rate_mem[1][stored] = it.rate_out;
            cap_mem[1][stored] = it.cap_out;
            stored++;
         end
         if (!it.last_peer) return;
         for (int i = 0; i < stored; i++) begin
            r.peer_index = i[4:0];
            r.new_cap_in = plan_one(0, stored, i);
            r.new_cap_out = plan_one(1, stored, i);
            r.last = (i + 1 == stored);
            exp_q[tail % QDEPTH] = r;
            tail++;
         end
         stored = 0;
      endfunction

      function void check_cap(rsp_type got);
         rsp_type exp;
         if (pending() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         exp = exp_q[head % QDEPTH];
         head++;
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", exp, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   cap_scoreboard sb;
   int idle_cycles;
   bit calm;

   peer_bandwidth_cap_allocator_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_cap(rsp_data);
      if (!reset && ((start && !busy) || (csr_valid && csr_ready) || rsp_valid))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_item(req_type it);
      if (!calm)
         while ($urandom_range(99) < 11) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      sb.note_item(it);
   endtask

   function automatic logic [31:0] pick(logic [31:0] scale);
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return (scale == 0) ? $urandom : $urandom_range(scale);
      endcase
   endfunction

   task automatic send_batch(int n, logic [31:0] scale, logic [31:0] plim);
      req_type it;
      for (int i = 0; i < n; i++) begin
         it.rate_in = pick(scale);
         it.rate_out = pick(scale);
         it.cap_in = ($urandom_range(3) == 0) ? plim : pick(scale);
         it.cap_out = ($urandom_range(3) == 0) ? plim : pick(scale);
         it.last_peer = (i == n - 1);
         send_item(it);
      end
   endtask

   task automatic configure(logic [31:0] ti, logic [31:0] to, logic [31:0] pi,
                            logic [31:0] po);
      write_reg(CSR_TOTAL_IN, ti);
      write_reg(CSR_TOTAL_OUT, to);
      write_reg(CSR_PEER_IN, pi);
      write_reg(CSR_PEER_OUT, po);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type it;
      logic [31:0] tot, plim;
      int sent;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TOTAL_IN;
      csr_data = '0;
      idle_cycles = 0;
      calm = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unlimited totals with reset peer limits
      it = '{rate_in: 32'hFFFF_FFFF, cap_in: 0, rate_out: 0, cap_out: 32'hFFFF_FFFF,
             last_peer: 1'b1};
      send_item(it);
      settle();
      // overshoot: heavy usage against a small total
      configure(32'd1000, 32'd2000, 32'd5000, 32'hFFFF_FFFF);
      send_batch(3, 32'd3000, 32'd5000);
      settle();
      // raise: light usage, some caps below share
      configure(32'd100000, 32'hFFFF_FFFF, 32'd60000, 32'd0);
      for (int i = 0; i < 4; i++) begin
         it = '{rate_in: 100 * i, cap_in: (i == 0) ? 32'd60000 : 32'd20000 * i,
                rate_out: 32'd7 * i, cap_out: 32'd3 * i, last_peer: (i == 3)};
         send_item(it);
      end
      settle();
      // store overflow: 34 items, last two dropped but the last still triggers
      configure(32'hFFFF_FFFF, 32'd12345, 32'hFFFF_FFFF, 32'd999);
      send_batch(34, 32'd0, 32'hFFFF_FFFF);
      settle();

      sent = 0;
      while (sent < 200) begin
         tot = $urandom_range(3) == 0 ? 32'd0 : pick(32'h0010_0000);
         plim = pick(32'h0008_0000);
         configure(tot, pick(32'h0010_0000), plim, pick(32'h0008_0000));
         for (int b = 0; b < 4; b++) begin
            int n;
            calm = ($urandom_range(5) == 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 33) : $urandom_range(1, 8);
            send_batch(n, ($urandom_range(1) == 0) ? tot / 4 + 1 : tot, plim);
            sent += n;
         end
         calm = 1'b0;
         settle();
      end
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_batch(5, 32'd0, 32'hFFFF_FFFF);
      settle();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

[filelist.f]
design/pbca_pkg.sv
design/pbca_div.sv
design/pbca_lane.sv
design/peer_bandwidth_cap_allocator_unit.sv
tb/sv/peer_bandwidth_cap_allocator_unit_test.sv
